/* rtl/cle_pkg.sv */
// Package for the console line editor: key codes, result codes and shared types.
package cle_pkg;

  localparam int DEFAULT_RING_DEPTH = 128;

  // Control keys
  localparam logic [7:0] KEY_CTRL_P = 8'h10;
  localparam logic [7:0] KEY_CTRL_U = 8'h15;
  localparam logic [7:0] KEY_CTRL_H = 8'h08;
  localparam logic [7:0] KEY_DEL    = 8'h7F;
  localparam logic [7:0] KEY_CR     = 8'h0D;
  localparam logic [7:0] KEY_CTRL_D = 8'h04;
  localparam logic [7:0] KEY_LF     = 8'h0A;
  localparam logic [7:0] KEY_NUL    = 8'h00;

  // Operation codes
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Echo kinds
  localparam logic [1:0] ECHO_NONE  = 2'd0;
  localparam logic [1:0] ECHO_CHAR  = 2'd1;
  localparam logic [1:0] ECHO_ERASE = 2'd2;

  // Read status codes
  localparam logic [1:0] RD_OK    = 2'd0;
  localparam logic [1:0] RD_EMPTY = 2'd1;
  localparam logic [1:0] RD_EOF   = 2'd2;

  typedef struct packed {
    logic       operation;
    logic [7:0] key_byte;
    logic       first_in_request;
  } in_item_t;

  typedef struct packed {
    logic [1:0] echo_kind;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic       line_ready;
    logic       dump_request;
    logic [1:0] read_status;
    logic [7:0] read_byte;
    logic       read_line_end;
  } result_t;

endpackage

/* rtl/cle_chan_if.sv */
// Handshake channel interfaces for key/read requests and their results.
interface cle_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] key_byte;
  logic       first_in_request;

  modport source (output valid, output operation, output key_byte,
                  output first_in_request, input ready);
  modport sink (input valid, input operation, input key_byte,
                input first_in_request, output ready);
endinterface

interface cle_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] echo_kind;
  logic [7:0] echo_char;
  logic [7:0] erase_count;
  logic       line_ready;
  logic       dump_request;
  logic [1:0] read_status;
  logic [7:0] read_byte;
  logic       read_line_end;

  modport source (output valid, output echo_kind, output echo_char,
                  output erase_count, output line_ready, output dump_request,
                  output read_status, output read_byte, output read_line_end,
                  input ready);
  modport sink (input valid, input echo_kind, input echo_char,
                input erase_count, input line_ready, input dump_request,
                input read_status, input read_byte, input read_line_end,
                output ready);
endinterface

/* rtl/cle_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cle_pkg::DEFAULT_RING_DEPTH
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/cle_edit.sv */
// Per-request edit logic: decodes one request against the ring indexes.
module cle_edit #(
  parameter int RING_DEPTH = cle_pkg::DEFAULT_RING_DEPTH
) (
  input  cle_pkg::in_item_t                    item,
  input  logic [$clog2(2*RING_DEPTH)-1:0]      read_idx,
  input  logic [$clog2(2*RING_DEPTH)-1:0]      commit_idx,
  input  logic [$clog2(2*RING_DEPTH)-1:0]      edit_idx,
  input  logic [7:0]                           ring_byte,
  output cle_pkg::result_t                     res,
  output logic [$clog2(2*RING_DEPTH)-1:0]      read_idx_nxt,
  output logic [$clog2(2*RING_DEPTH)-1:0]      commit_idx_nxt,
  output logic [$clog2(2*RING_DEPTH)-1:0]      edit_idx_nxt,
  output logic                                 wr_en,
  output logic [$clog2(RING_DEPTH)-1:0]        wr_slot,
  output logic [7:0]                           wr_data
);

  localparam int IDX_W  = $clog2(2*RING_DEPTH);
  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam logic [IDX_W-1:0] IDX_DEPTH = IDX_W'(RING_DEPTH);
  localparam logic [IDX_W-1:0] IDX_MOD   = IDX_W'(2*RING_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(2*RING_DEPTH - 1);
  localparam logic [IDX_W-1:0] IDX_SAT   = IDX_W'(255);

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] a);
    idx_inc = (a == IDX_LAST) ? '0 : a + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] a);
    idx_dec = (a == '0) ? IDX_LAST : a - IDX_W'(1);
  endfunction

  // Result always fits IDX_W bits, so the modular wrap is exact.
  function automatic logic [IDX_W-1:0] idx_dist(input logic [IDX_W-1:0] hi,
                                                input logic [IDX_W-1:0] lo);
    idx_dist = (hi >= lo) ? hi - lo : hi + IDX_MOD - lo;
  endfunction

  logic [IDX_W-1:0] line_len;
  logic [IDX_W-1:0] edit_inc;
  logic [7:0]       store_char;
  logic             has_room;

  assign line_len   = idx_dist(edit_idx, commit_idx);
  assign edit_inc   = idx_inc(edit_idx);
  assign store_char = (item.key_byte == cle_pkg::KEY_CR) ? cle_pkg::KEY_LF : item.key_byte;
  assign has_room   = idx_dist(edit_idx, read_idx) < IDX_DEPTH;
  assign wr_slot    = (edit_idx >= IDX_DEPTH) ? SLOT_W'(edit_idx - IDX_DEPTH)
                                              : SLOT_W'(edit_idx);
  assign wr_data    = store_char;

  always_comb begin
    res            = '0;
    read_idx_nxt   = read_idx;
    commit_idx_nxt = commit_idx;
    edit_idx_nxt   = edit_idx;
    wr_en          = 1'b0;

    if (item.operation == cle_pkg::OP_KEY) begin
      if (item.key_byte == cle_pkg::KEY_CTRL_P) begin
        res.dump_request = 1'b1;
      end else if (item.key_byte == cle_pkg::KEY_CTRL_U) begin
        edit_idx_nxt = commit_idx;
        if (line_len != '0) begin
          res.echo_kind   = cle_pkg::ECHO_ERASE;
          res.erase_count = (line_len > IDX_SAT) ? 8'd255 : 8'(line_len);
        end
      end else if (item.key_byte == cle_pkg::KEY_CTRL_H ||
                   item.key_byte == cle_pkg::KEY_DEL) begin
        if (edit_idx != commit_idx) begin
          edit_idx_nxt    = idx_dec(edit_idx);
          res.echo_kind   = cle_pkg::ECHO_ERASE;
          res.erase_count = 8'd1;
        end
      end else if (item.key_byte != cle_pkg::KEY_NUL && has_room) begin
        wr_en         = 1'b1;
        edit_idx_nxt  = edit_inc;
        res.echo_kind = cle_pkg::ECHO_CHAR;
        res.echo_char = store_char;
        // Commit on newline, end of file, or a ring that just filled up
        if (store_char == cle_pkg::KEY_LF || store_char == cle_pkg::KEY_CTRL_D ||
            idx_dist(edit_inc, read_idx) == IDX_DEPTH) begin
          commit_idx_nxt = edit_inc;
          res.line_ready = 1'b1;
        end
      end
    end else begin
      if (read_idx == commit_idx) begin
        res.read_status = cle_pkg::RD_EMPTY;
      end else if (ring_byte == cle_pkg::KEY_CTRL_D) begin
        res.read_status = cle_pkg::RD_EOF;
        if (item.first_in_request) begin
          read_idx_nxt = idx_inc(read_idx);
        end
      end else begin
        read_idx_nxt      = idx_inc(read_idx);
        res.read_byte     = ring_byte;
        res.read_line_end = (ring_byte == cle_pkg::KEY_LF);
      end
    end
  end

endmodule

/* rtl/console_line_editor_top.sv */
// Top level of the console line editor: request/result registers, indexes and line ring.
//
// Usage:
//   in_chan carries requests: operation 0 delivers a typed key_byte, operation 1
//   asks for one committed byte (first_in_request marks the first byte of a
//   read call). out_chan carries exactly one result per request, in order:
//   echo action, line commit and dump flags for keys; status and byte for reads.
//   An accepted request sits in the input register, is decoded against the ring
//   indexes and moves into the result register once that register is free.
//   Throughput: one request per cycle unless out_chan stalls. The single ring
//   read port always prefetches the byte at the read index, with a forward
//   path when a key is written to that same slot, so consecutive reads need
//   no bubble.
//   Reset (rst_n low, synchronous) empties the ring by zeroing all three
//   indexes and drops any request in flight; ring contents are left as is.
//   When out_chan.ready is low the result register holds, the input register
//   keeps its request, and in_chan.ready falls once both are full.
module console_line_editor_top #(
  parameter int RING_DEPTH = cle_pkg::DEFAULT_RING_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  cle_in_if.sink           in_chan,
  cle_out_if.source        out_chan
);

  localparam int IDX_W  = $clog2(2*RING_DEPTH);
  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam logic [IDX_W-1:0] IDX_DEPTH = IDX_W'(RING_DEPTH);
  localparam logic [IDX_W-1:0] IDX_MOD   = IDX_W'(2*RING_DEPTH);

  // Input register stage
  logic              s1_valid_r;
  cle_pkg::in_item_t s1_item_r;

  // Result register stage
  logic              out_valid_r;
  cle_pkg::result_t  out_res_r;

  // Ring indexes, each counting modulo twice the depth
  logic [IDX_W-1:0]  read_idx_r,   read_idx_nxt;
  logic [IDX_W-1:0]  commit_idx_r, commit_idx_nxt;
  logic [IDX_W-1:0]  edit_idx_r,   edit_idx_nxt;

  // Edit logic outputs
  cle_pkg::result_t  step_res;
  logic [IDX_W-1:0]  step_read_nxt, step_commit_nxt, step_edit_nxt;
  logic              step_wr_en;
  logic [SLOT_W-1:0] wr_slot;
  logic [7:0]        wr_data;

  // Ring read path with forwarding
  logic [SLOT_W-1:0] rd_slot;
  logic [7:0]        ram_q;
  logic              fwd_hit_r;
  logic [7:0]        fwd_data_r;
  logic [7:0]        ring_byte;
  logic              wr_en;

  logic              fire;

  // Advance the input stage only when the result register can take its result
  assign fire          = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || fire;

  cle_edit #(
    .RING_DEPTH (RING_DEPTH)
  ) u_edit (
    .item           (s1_item_r),
    .read_idx       (read_idx_r),
    .commit_idx     (commit_idx_r),
    .edit_idx       (edit_idx_r),
    .ring_byte      (ring_byte),
    .res            (step_res),
    .read_idx_nxt   (step_read_nxt),
    .commit_idx_nxt (step_commit_nxt),
    .edit_idx_nxt   (step_edit_nxt),
    .wr_en          (step_wr_en),
    .wr_slot        (wr_slot),
    .wr_data        (wr_data)
  );

  assign wr_en          = fire && step_wr_en;
  assign read_idx_nxt   = fire ? step_read_nxt   : read_idx_r;
  assign commit_idx_nxt = fire ? step_commit_nxt : commit_idx_r;
  assign edit_idx_nxt   = fire ? step_edit_nxt   : edit_idx_r;

  // Prefetch the slot that the next read index points at
  assign rd_slot = (read_idx_nxt >= IDX_DEPTH) ? SLOT_W'(read_idx_nxt - IDX_DEPTH)
                                               : SLOT_W'(read_idx_nxt);

  cle_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_slot),
    .wr_data (wr_data),
    .rd_addr (rd_slot),
    .rd_data (ram_q)
  );

  // The RAM returns old data on a same-slot write; forward the new byte instead
  assign ring_byte = fwd_hit_r ? fwd_data_r : ram_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else begin
      fwd_hit_r <= wr_en && (wr_slot == rd_slot);
    end
    fwd_data_r <= wr_data;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_item_r.operation        <= in_chan.operation;
      s1_item_r.key_byte         <= in_chan.key_byte;
      s1_item_r.first_in_request <= in_chan.first_in_request;
    end
  end

  // Index registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_idx_r   <= '0;
      commit_idx_r <= '0;
      edit_idx_r   <= '0;
    end else begin
      read_idx_r   <= read_idx_nxt;
      commit_idx_r <= commit_idx_nxt;
      edit_idx_r   <= edit_idx_nxt;
    end
  end

  // Result register: load on fire, drop once the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= step_res;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.echo_kind     = out_res_r.echo_kind;
  assign out_chan.echo_char     = out_res_r.echo_char;
  assign out_chan.erase_count   = out_res_r.erase_count;
  assign out_chan.line_ready    = out_res_r.line_ready;
  assign out_chan.dump_request  = out_res_r.dump_request;
  assign out_chan.read_status   = out_res_r.read_status;
  assign out_chan.read_byte     = out_res_r.read_byte;
  assign out_chan.read_line_end = out_res_r.read_line_end;

  // Occupancy spans measured from the read index
  logic [IDX_W-1:0] edit_span;
  logic [IDX_W-1:0] commit_span;

  assign edit_span   = (edit_idx_r >= read_idx_r) ? edit_idx_r - read_idx_r
                                                  : edit_idx_r + IDX_MOD - read_idx_r;
  assign commit_span = (commit_idx_r >= read_idx_r) ? commit_idx_r - read_idx_r
                                                    : commit_idx_r + IDX_MOD - read_idx_r;

  a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
    edit_span <= IDX_DEPTH)
    else $error("ring holds more bytes than its depth");

  a_commit_order: assert property (@(posedge clk) disable iff (!rst_n)
    commit_span <= edit_span)
    else $error("commit index ran past the edit index");

  a_commit_closes_line: assert property (@(posedge clk) disable iff (!rst_n)
    fire && step_res.line_ready |=> commit_idx_r == edit_idx_r)
    else $error("committed line left uncommitted bytes behind");

endmodule

/* sim/cle_checker.sv */
// Checker for the console line editor: predicts each result and compares it with the block.
module cle_checker #(
  parameter int RING_DEPTH = cle_pkg::DEFAULT_RING_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  cle_in_if    in_chan,
  cle_out_if   out_chan,
  output int   fail_count
);

  localparam int POS_W = $clog2(RING_DEPTH) + 1;

  logic [7:0]       line_copy [RING_DEPTH];
  logic [POS_W-1:0] read_pos;
  logic [POS_W-1:0] commit_pos;
  logic [POS_W-1:0] edit_pos;

  cle_pkg::result_t  results_due [$];
  cle_pkg::result_t  want;
  cle_pkg::result_t  got;
  cle_pkg::in_item_t req;

  // Apply one request to the line copy and return the result it must produce.
  function automatic cle_pkg::result_t editor_step(cle_pkg::in_item_t r);
    cle_pkg::result_t res;
    logic [POS_W-1:0] span;
    logic [7:0]       ch;
    res = '0;
    if (r.operation == cle_pkg::OP_KEY) begin
      if (r.key_byte == cle_pkg::KEY_CTRL_P) begin
        res.dump_request = 1'b1;
      end else if (r.key_byte == cle_pkg::KEY_CTRL_U) begin
        span = edit_pos - commit_pos;
        if (span != 0) begin
          res.echo_kind   = cle_pkg::ECHO_ERASE;
          res.erase_count = (span > 255) ? 8'd255 : 8'(span);
        end
        edit_pos = commit_pos;
      end else if (r.key_byte == cle_pkg::KEY_CTRL_H || r.key_byte == cle_pkg::KEY_DEL) begin
        if (edit_pos != commit_pos) begin
          edit_pos        = edit_pos - 1'b1;
          res.echo_kind   = cle_pkg::ECHO_ERASE;
          res.erase_count = 8'd1;
        end
      end else begin
        span = edit_pos - read_pos;
        if (r.key_byte != cle_pkg::KEY_NUL && span < RING_DEPTH) begin
          ch = (r.key_byte == cle_pkg::KEY_CR) ? cle_pkg::KEY_LF : r.key_byte;
          line_copy[edit_pos[POS_W-2:0]] = ch;
          edit_pos      = edit_pos + 1'b1;
          res.echo_kind = cle_pkg::ECHO_CHAR;
          res.echo_char = ch;
          span = edit_pos - read_pos;
          if (ch == cle_pkg::KEY_LF || ch == cle_pkg::KEY_CTRL_D || span == RING_DEPTH) begin
            commit_pos     = edit_pos;
            res.line_ready = 1'b1;
          end
        end
      end
    end else begin
      if (read_pos == commit_pos) begin
        res.read_status = cle_pkg::RD_EMPTY;
      end else begin
        ch = line_copy[read_pos[POS_W-2:0]];
        if (ch == cle_pkg::KEY_CTRL_D) begin
          res.read_status = cle_pkg::RD_EOF;
          if (r.first_in_request) read_pos = read_pos + 1'b1;
        end else begin
          read_pos          = read_pos + 1'b1;
          res.read_byte     = ch;
          res.read_line_end = (ch == cle_pkg::KEY_LF);
        end
      end
    end
    return res;
  endfunction

  task automatic check_field(string what, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      read_pos   = '0;
      commit_pos = '0;
      edit_pos   = '0;
      results_due.delete();
      foreach (line_copy[i]) line_copy[i] = 8'd0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got = {out_chan.echo_kind, out_chan.echo_char, out_chan.erase_count,
               out_chan.line_ready, out_chan.dump_request, out_chan.read_status,
               out_chan.read_byte, out_chan.read_line_end};
        if (results_due.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, actual %h", $time, got);
        end else begin
          want = results_due.pop_front();
          check_field("echo_kind", 32'(want.echo_kind), 32'(got.echo_kind));
          check_field("echo_char", 32'(want.echo_char), 32'(got.echo_char));
          check_field("erase_count", 32'(want.erase_count), 32'(got.erase_count));
          check_field("line_ready", 32'(want.line_ready), 32'(got.line_ready));
          check_field("dump_request", 32'(want.dump_request), 32'(got.dump_request));
          check_field("read_status", 32'(want.read_status), 32'(got.read_status));
          check_field("read_byte", 32'(want.read_byte), 32'(got.read_byte));
          check_field("read_line_end", 32'(want.read_line_end), 32'(got.read_line_end));
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        req = {in_chan.operation, in_chan.key_byte, in_chan.first_in_request};
        results_due.push_back(editor_step(req));
      end
    end
  end

endmodule

/* sim/testbench.sv */
// Testbench top for the console line editor: clock, reset, request stimulus and verdict.
module testbench;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   sent_count;
  int   results_seen;
  int   burst_left;
  bit   offering;
  bit   held_off;
  int   len;
  int   pick;

  cle_in_if  in_ch ();
  cle_out_if out_ch ();

  console_line_editor_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  cle_checker line_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_ch),
    .out_chan   (out_ch),
    .fail_count (fail_count)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Count results taken so the end of the run can wait for the last one.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) results_seen++;
  end

  // Offer one request and hold it until the block takes it. Bursts of random
  // length are separated by random gaps; with no gap, valid stays high and the
  // next request follows straight after the one taken.
  task automatic offer(logic op, logic [7:0] key, logic first);
    int gap;
    in_ch.valid            <= 1'b1;
    in_ch.operation        <= op;
    in_ch.key_byte         <= key;
    in_ch.first_in_request <= first;
    offering = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = $urandom_range(5);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Type a line body. With editing on, mix in erase, kill and dump keys and
  // the odd control byte; with it off, type printable bytes only.
  task automatic type_line(int count, bit editing);
    int         r;
    logic [7:0] ch;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (!editing) ch = 8'($urandom_range(8'h20, 8'h7E));
      else if (r < 80) ch = 8'($urandom_range(8'h20, 8'hFF));
      else if (r < 90) ch = r[0] ? cle_pkg::KEY_CTRL_H : cle_pkg::KEY_DEL;
      else if (r < 95) ch = cle_pkg::KEY_CTRL_U;
      else if (r < 97) ch = cle_pkg::KEY_CTRL_P;
      else ch = 8'($urandom_range(8'h01, 8'h1F));
      offer(cle_pkg::OP_KEY, ch, 1'($urandom_range(1)));
    end
  endtask

  // Issue one read call: the first byte carries the request-start flag.
  task automatic read_back(int count);
    for (int i = 0; i < count; i++)
      offer(cle_pkg::OP_READ, 8'($urandom_range(255)), i == 0);
  endtask

  // Receiver: switch every so often between always ready, random stalls and a
  // stall pattern, and hold off once for a long stretch while the sender keeps
  // offering, so the block fills up and drops its input ready.
  initial begin : receiver
    int         phase;
    int         mode;
    logic [7:0] pattern;
    phase   = 0;
    mode    = 0;
    pattern = 8'hA5;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held_off && sent_count >= 200) begin
        held_off = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (48) @(posedge clk);
      end else begin
        phase++;
        if (phase % 50 == 0) begin
          mode    = $urandom_range(2);
          pattern = 8'($urandom_range(1, 255));
        end
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(1));
          default: out_ch.ready <= pattern[phase[2:0]];
        endcase
      end
    end
  end

  initial begin
    rst_n                  <= 1'b0;
    in_ch.valid            <= 1'b0;
    in_ch.operation        <= cle_pkg::OP_KEY;
    in_ch.key_byte         <= cle_pkg::KEY_NUL;
    in_ch.first_in_request <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty reads, control keys on an empty line, ignored NUL,
    // erase and kill with characters present, CR turned into LF, EOF left in
    // place mid-request and consumed at the start of one.
    offer(cle_pkg::OP_READ, 8'h00, 1'b1);
    offer(cle_pkg::OP_READ, 8'hFF, 1'b0);
    offer(cle_pkg::OP_KEY, cle_pkg::KEY_CTRL_P, 1'b0);
    offer(cle_pkg::OP_KEY, cle_pkg::KEY_CTRL_U, 1'b1);
    offer(cle_pkg::OP_KEY, cle_pkg::KEY_CTRL_H, 1'b0);
    offer(cle_pkg::OP_KEY, cle_pkg::KEY_DEL, 1'b0);
    offer(cle_pkg::OP_KEY, cle_pkg::KEY_NUL, 1'b1);
    offer(cle_pkg::OP_KEY, 8'hFF, 1'b0);
    offer(cle_pkg::OP_KEY, 8'h61, 1'b0);
    offer(cle_pkg::OP_KEY, cle_pkg::KEY_CTRL_H, 1'b0);
    offer(cle_pkg::OP_KEY, 8'h62, 1'b0);
    offer(cle_pkg::OP_KEY, cle_pkg::KEY_DEL, 1'b0);
    offer(cle_pkg::OP_KEY, 8'h63, 1'b0);
    offer(cle_pkg::OP_KEY, 8'h64, 1'b0);
    offer(cle_pkg::OP_KEY, cle_pkg::KEY_CTRL_U, 1'b0);
    offer(cle_pkg::OP_KEY, 8'h78, 1'b0);
    offer(cle_pkg::OP_KEY, cle_pkg::KEY_CR, 1'b0);
    read_back(2);
    offer(cle_pkg::OP_KEY, cle_pkg::KEY_CTRL_D, 1'b0);
    offer(cle_pkg::OP_READ, 8'h00, 1'b0);
    offer(cle_pkg::OP_READ, 8'h00, 1'b1);
    offer(cle_pkg::OP_READ, 8'h00, 1'b1);
    offer(cle_pkg::OP_KEY, 8'h80, 1'b0);
    offer(cle_pkg::OP_KEY, cle_pkg::KEY_LF, 1'b0);
    read_back(3);

    // Fill the ring with no line end: it commits when full and then drops keys.
    type_line(135, 1'b0);
    read_back(130);
    // Kill a long line in one go.
    type_line(100, 1'b0);
    offer(cle_pkg::OP_KEY, cle_pkg::KEY_CTRL_U, 1'b0);
    offer(cle_pkg::OP_KEY, cle_pkg::KEY_LF, 1'b0);
    read_back(2);

    // Random: mostly edited lines read back by a reader, some EOF handling,
    // and raw noise.
    while (sent_count < 520) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 14);
        type_line(len, 1'b1);
        case ($urandom_range(2))
          0: offer(cle_pkg::OP_KEY, cle_pkg::KEY_LF, 1'b0);
          1: offer(cle_pkg::OP_KEY, cle_pkg::KEY_CR, 1'b0);
          default: offer(cle_pkg::OP_KEY, cle_pkg::KEY_CTRL_D, 1'b0);
        endcase
        read_back($urandom_range(len / 2, len + 3));
      end else if (pick < 80) begin
        offer(cle_pkg::OP_KEY, cle_pkg::KEY_CTRL_D, 1'b0);
        offer(cle_pkg::OP_READ, 8'($urandom_range(255)), 1'b0);
        offer(cle_pkg::OP_READ, 8'($urandom_range(255)), 1'b1);
      end else begin
        repeat ($urandom_range(1, 6))
          offer(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
    if (offering) in_ch.valid <= 1'b0;

    // Drain: wait for every result, then idle on to catch anything stray.
    wait (results_seen == sent_count);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS console_line_editor_top");
    end else begin
      $display("FAIL console_line_editor_top");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #400000;
    $display("FAIL console_line_editor_top");
    $finish;
  end

endmodule
